@@ sv/gsfd_pkg.sv @@
// ----------------------------------------------------------------------------
// Gas sensor frame deframer package
// Frame constants, unit codes and the reciprocal table used for the division
// by powers of ten in the concentration conversion.
// ----------------------------------------------------------------------------
`default_nettype none

package gsfd_pkg;

   localparam int unsigned WinLen = 8;

   localparam logic [7:0] SYNC_BYTE = 8'hFF;
   localparam logic [7:0] QUERY_CMD = 8'h86;
   localparam logic [7:0] GAS_A     = 8'h11;
   localparam logic [7:0] GAS_B     = 8'h17;
   localparam logic [7:0] UNIT_PPB  = 8'h04;
   localparam logic [7:0] UNIT_UGM3 = 8'h10;
   localparam logic [7:0] MAX_DEC   = 8'd5;

   localparam logic FRAME_QUERY  = 1'b0;
   localparam logic FRAME_ACTIVE = 1'b1;

   typedef logic [7:0]  byte_type;
   typedef logic [15:0] half_type;

   // Scaled numerator: at most 8 * 65535, which needs 19 of the 20 bits.
   typedef logic [19:0] num_type;
   typedef logic [20:0] recip_type;
   typedef logic [40:0] prod_type;
   typedef logic [5:0]  shift_type;
   typedef logic [2:0]  pow_type;

   // Multipliers ceil(2^s / 10^k) with s = 20 + ceil(log2(10^k)), m = 1 and
   // s = 0 for k = 0: (n * m) >> s is exactly floor(n / 10^k) for all 20-bit n.
   function automatic recip_type recip_mult(input pow_type k);
      recip_type m;
      case (k)
         3'd0:    m = 21'd1;
         3'd1:    m = 21'd1677722;
         3'd2:    m = 21'd1342178;
         3'd3:    m = 21'd1073742;
         3'd4:    m = 21'd1717987;
         3'd5:    m = 21'd1374390;
         default: m = 21'd0;
      endcase
      return m;
   endfunction

   function automatic shift_type recip_shift(input pow_type k);
      shift_type s;
      case (k)
         3'd0:    s = 6'd0;
         3'd1:    s = 6'd24;
         3'd2:    s = 6'd27;
         3'd3:    s = 6'd30;
         3'd4:    s = 6'd34;
         3'd5:    s = 6'd37;
         default: s = 6'd0;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

@@ sv/gsfd_convert.sv @@
// ----------------------------------------------------------------------------
// Gas sensor frame deframer: active frame conversion
// Converts the raw concentration of an active upload frame into mass and
// volume concentration according to the unit code and decimal places.
// ----------------------------------------------------------------------------
`default_nettype none

module gsfd_convert
   import gsfd_pkg::*;
(
   input  wire half_type conc_raw,
   input  wire byte_type unit_code,
   input  wire byte_type decimals,
   output half_type      mass_conc,
   output half_type      volume_conc
);

   logic      is_ppb;
   logic      is_ugm3;
   logic      too_many_dec;
   num_type   numer;
   pow_type   pow_sel;
   prod_type  product;
   num_type   quot;
   logic [17:0] mass_raw;

   assign is_ppb       = (unit_code == UNIT_PPB);
   assign is_ugm3      = (unit_code == UNIT_UGM3);
   assign too_many_dec = (decimals >= MAX_DEC);

   // ppb to ug/m3 is c*5/(4*10^d): divide 5c by 10^d, then by four.
   // ug/m3 to ppb is c*4/(5*10^d), which equals 8c/10^(d+1).
   always_comb begin
      if (is_ppb) begin
         numer   = {2'b00, conc_raw, 2'b00} + {4'b0000, conc_raw};
         pow_sel = decimals[2:0];
      end else begin
         numer   = {1'b0, conc_raw, 3'b000};
         pow_sel = decimals[2:0] + 3'd1;
      end
   end

   assign product  = prod_type'(numer) * prod_type'(recip_mult(pow_sel));
   assign quot     = num_type'(product >> recip_shift(pow_sel));
   assign mass_raw = quot[19:2];

   always_comb begin
      if (is_ppb) begin
         volume_conc = conc_raw;
         if (too_many_dec) begin
            mass_conc = '0;
         end else if (mass_raw[17:16] != 2'b00) begin
            mass_conc = 16'hFFFF;
         end else begin
            mass_conc = mass_raw[15:0];
         end
      end else if (is_ugm3) begin
         mass_conc = conc_raw;
         if (too_many_dec) begin
            volume_conc = '0;
         end else begin
            volume_conc = quot[15:0];
         end
      end else begin
         volume_conc = conc_raw;
         mass_conc   = '0;
      end
   end

endmodule

`default_nettype wire

@@ sv/gas_sensor_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// Gas sensor frame deframer
// Slides a nine-byte window over the received serial bytes, recognises query
// response and active upload frames and emits their concentration fields.
// ----------------------------------------------------------------------------
// The byte that ends a frame loads the input register on acceptance, and the
// result register loads when no earlier result word is still waiting.
// Throughput: one byte per cycle, but a byte that completes a frame waits while
// the result register holds an untaken word; the frame check, checksum and the
// single reciprocal multiply for the conversion sit between those two registers.
// Reset clears the window, the pipeline valids and sets active mode.
`default_nettype none

module gas_sensor_frame_deframer
   import gsfd_pkg::*;
(
   input  wire        clock,
   input  wire        reset,

   input  wire        csr_valid,
   output logic       csr_ready,
   input  wire        csr_active_mode,

   input  wire        req_valid,
   output logic       req_ready,
   input  wire [7:0]  req_rx_byte,

   output logic       rsp_valid,
   input  wire        rsp_ready,
   output logic       rsp_frame_kind,
   output logic [15:0] rsp_mass_conc,
   output logic [15:0] rsp_volume_conc,
   output logic [7:0] rsp_gas_code,
   output logic [7:0] rsp_unit_code,
   output logic [7:0] rsp_decimals,
   output logic [15:0] rsp_full_scale
);

   logic     active_mode_ff;

   logic     in_valid_ff;
   logic     in_valid_in;
   byte_type in_byte_ff;

   byte_type window_ff [WinLen];

   logic     rsp_valid_ff;
   logic     rsp_valid_in;
   logic     frame_kind_ff;
   half_type mass_conc_ff;
   half_type volume_conc_ff;
   byte_type gas_code_ff;
   byte_type unit_code_ff;
   byte_type decimals_ff;
   half_type full_scale_ff;

   logic     cmd_ok;
   logic     is_frame;
   byte_type checksum;
   logic     advance;
   logic     load_rsp;
   half_type conv_mass;
   half_type conv_volume;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_mode_ff <= 1'b1;
      end else if (csr_valid) begin
         active_mode_ff <= csr_active_mode;
      end
   end

   // Frame check on the stored eight bytes plus the byte in the input register.
   always_comb begin
      checksum = in_byte_ff;
      for (int i = 1; i < WinLen; i++) begin
         checksum = checksum + window_ff[i];
      end
   end

   always_comb begin
      if (active_mode_ff) begin
         cmd_ok = (window_ff[1] == GAS_A) || (window_ff[1] == GAS_B);
      end else begin
         cmd_ok = (window_ff[1] == QUERY_CMD);
      end
   end

   assign is_frame = (window_ff[0] == SYNC_BYTE) && cmd_ok && (checksum == 8'h00);

   // A byte that completes no frame never waits on the result side.
   assign advance   = in_valid_ff && (!is_frame || !rsp_valid_ff || rsp_ready);
   assign load_rsp  = advance && is_frame;
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in = req_valid || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WinLen; i++) begin
            window_ff[i] <= '0;
         end
      end else if (load_rsp) begin
         for (int i = 0; i < WinLen; i++) begin
            window_ff[i] <= '0;
         end
      end else if (advance) begin
         for (int i = 0; i < WinLen - 1; i++) begin
            window_ff[i] <= window_ff[i + 1];
         end
         window_ff[WinLen - 1] <= in_byte_ff;
      end
   end

   gsfd_convert u_convert (
      .conc_raw    ({window_ff[4], window_ff[5]}),
      .unit_code   (window_ff[2]),
      .decimals    (window_ff[3]),
      .mass_conc   (conv_mass),
      .volume_conc (conv_volume)
   );

   assign rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         if (active_mode_ff) begin
            frame_kind_ff  <= FRAME_ACTIVE;
            mass_conc_ff   <= conv_mass;
            volume_conc_ff <= conv_volume;
            gas_code_ff    <= window_ff[1];
            unit_code_ff   <= window_ff[2];
            decimals_ff    <= window_ff[3];
            full_scale_ff  <= {window_ff[6], window_ff[7]};
         end else begin
            frame_kind_ff  <= FRAME_QUERY;
            mass_conc_ff   <= {window_ff[2], window_ff[3]};
            volume_conc_ff <= {window_ff[6], window_ff[7]};
            gas_code_ff    <= '0;
            unit_code_ff   <= '0;
            decimals_ff    <= '0;
            full_scale_ff  <= '0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_frame_kind  = frame_kind_ff;
   assign rsp_mass_conc   = mass_conc_ff;
   assign rsp_volume_conc = volume_conc_ff;
   assign rsp_gas_code    = gas_code_ff;
   assign rsp_unit_code   = unit_code_ff;
   assign rsp_decimals    = decimals_ff;
   assign rsp_full_scale  = full_scale_ff;

endmodule

`default_nettype wire

@@ tb/tb_gas_sensor_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// Gas sensor frame deframer testbench
// Feeds received serial bytes, carrying well-formed frames with random content,
// broken frames and noise, through the deframer in both modes, and checks every
// result word field by field against a predictor of the nine-byte window.
// ----------------------------------------------------------------------------

module tb_gas_sensor_frame_deframer
   import gsfd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CycleLimit  = 400000;
   localparam int unsigned PhaseBytes  = 60;
   localparam int unsigned LongHoldOff = 300;

   typedef struct {
      logic     kind;
      half_type mass;
      half_type vol;
      byte_type gas;
      byte_type unit;
      byte_type dec;
      half_type fs;
   } conc_reading_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_valid = 1'b0;
   logic       csr_active_mode = 1'b0;
   logic       req_valid = 1'b0;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_ready = 1'b0;

   wire        csr_ready;
   wire        req_ready;
   wire        rsp_valid;
   wire        rsp_frame_kind;
   wire [15:0] rsp_mass_conc;
   wire [15:0] rsp_volume_conc;
   wire [7:0]  rsp_gas_code;
   wire [7:0]  rsp_unit_code;
   wire [7:0]  rsp_decimals;
   wire [15:0] rsp_full_scale;

   gas_sensor_frame_deframer dut (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_active_mode (csr_active_mode),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_frame_kind  (rsp_frame_kind),
      .rsp_mass_conc   (rsp_mass_conc),
      .rsp_volume_conc (rsp_volume_conc),
      .rsp_gas_code    (rsp_gas_code),
      .rsp_unit_code   (rsp_unit_code),
      .rsp_decimals    (rsp_decimals),
      .rsp_full_scale  (rsp_full_scale)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predictor state: the stored bytes, oldest first, and the mode register.
   byte_type         rx_window [WinLen] = '{default: 8'h00};
   logic             mode_now = 1'b1;

   byte_type         pending_bytes [$];
   conc_reading_type expected_readings [$];

   int unsigned   mismatches = 0;
   int unsigned   cycle_count = 0;
   int unsigned   bytes_pushed = 0;
   bit            byte_taken = 1'b0;
   bit            word_taken = 1'b0;
   bit            send_idle_on = 1'b0;
   bit            recv_idle_on = 1'b0;
   int unsigned   hold_request = 0;

   task automatic report(input string msg);
      $display("%s", msg);
      mismatches++;
   endtask

   // Says if a byte completes a frame, which clears the window, else shifts it in.
   function automatic bit deframe_byte(input byte_type rx, output conc_reading_type r);
      byte_type    f [9];
      byte_type    sum;
      bit          cmd_ok;
      logic [63:0] c;
      logic [63:0] p;
      logic [63:0] m;
      logic [63:0] v;
      r = '{default: '0};
      for (int i = 0; i < WinLen; i++) f[i] = rx_window[i];
      f[8] = rx;
      sum = 8'h00;
      for (int i = 1; i < 9; i++) sum = sum + f[i];
      if (mode_now) cmd_ok = (f[1] == GAS_A) || (f[1] == GAS_B);
      else cmd_ok = (f[1] == QUERY_CMD);
      if (f[0] != SYNC_BYTE || !cmd_ok || sum != 8'h00) begin
         for (int i = 0; i < WinLen - 1; i++) rx_window[i] = rx_window[i + 1];
         rx_window[WinLen - 1] = rx;
         return 1'b0;
      end
      rx_window = '{default: 8'h00};
      if (!mode_now) begin
         r.kind = FRAME_QUERY;
         r.mass = {f[2], f[3]};
         r.vol  = {f[6], f[7]};
         return 1'b1;
      end
      c = {48'd0, f[4], f[5]};
      p = 64'd1;
      for (int i = 0; i < f[3] && i < MAX_DEC; i++) p = p * 64'd10;
      if (f[2] == UNIT_PPB) begin
         v = c;
         m = (c * 64'd5) / (64'd4 * p);
         if (m > 64'hFFFF) m = 64'hFFFF;
      end else if (f[2] == UNIT_UGM3) begin
         m = c;
         v = (c * 64'd4) / (64'd5 * p);
      end else begin
         v = c;
         m = 64'd0;
      end
      r.kind = FRAME_ACTIVE;
      r.mass = m[15:0];
      r.vol  = v[15:0];
      r.gas  = f[1];
      r.unit = f[2];
      r.dec  = f[3];
      r.fs   = {f[6], f[7]};
      return 1'b1;
   endfunction

   // Sampling at the rising edge: accepted bytes feed the predictor, accepted
   // result words are checked against the oldest expectation.
   always @(posedge clock) begin
      conc_reading_type r;
      conc_reading_type want;
      byte_taken = !reset && req_valid && req_ready;
      word_taken = !reset && rsp_valid && rsp_ready;
      if (!reset && csr_valid && csr_ready) mode_now = csr_active_mode;
      if (byte_taken && deframe_byte(req_rx_byte, r)) expected_readings.push_back(r);
      if (word_taken) begin
         if (expected_readings.size() == 0) begin
            report("result word arrived with no frame outstanding");
         end else begin
            want = expected_readings.pop_front();
            if (rsp_frame_kind !== want.kind)
               report($sformatf("frame_kind: got %h, expected %h", rsp_frame_kind, want.kind));
            if (rsp_mass_conc !== want.mass)
               report($sformatf("mass_conc: got %h, expected %h", rsp_mass_conc, want.mass));
            if (rsp_volume_conc !== want.vol)
               report($sformatf("volume_conc: got %h, expected %h",
                                rsp_volume_conc, want.vol));
            if (rsp_gas_code !== want.gas)
               report($sformatf("gas_code: got %h, expected %h", rsp_gas_code, want.gas));
            if (rsp_unit_code !== want.unit)
               report($sformatf("unit_code: got %h, expected %h", rsp_unit_code, want.unit));
            if (rsp_decimals !== want.dec)
               report($sformatf("decimals: got %h, expected %h", rsp_decimals, want.dec));
            if (rsp_full_scale !== want.fs)
               report($sformatf("full_scale: got %h, expected %h", rsp_full_scale, want.fs));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   // Byte sender: a word stays on the bus until taken, then the next one
   // follows, after a random gap when send_idle_on is set.
   int unsigned send_gap = 0;

   always @(negedge clock) begin
      logic     nxt_valid;
      byte_type nxt_byte;
      nxt_valid = req_valid;
      nxt_byte  = req_rx_byte;
      if (reset) begin
         nxt_valid = 1'b0;
      end else begin
         if (req_valid && byte_taken) nxt_valid = 1'b0;
         if (!nxt_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_bytes.size() > 0) begin
               nxt_valid = 1'b1;
               nxt_byte  = pending_bytes.pop_front();
               send_gap  = send_idle_on ? $urandom_range(0, 7) : 0;
            end
         end
      end
      req_valid   <= nxt_valid;
      req_rx_byte <= nxt_byte;
   end

   // Result receiver: a random stall after each word while recv_idle_on is set,
   // plus a long hold-off on request, counted down here.
   int unsigned recv_stall = 0;
   int unsigned hold_left = 0;

   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (word_taken) recv_stall = recv_idle_on ? $urandom_range(0, 7) : 0;
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic push_byte(input byte_type b);
      pending_bytes.push_back(b);
      bytes_pushed++;
   endtask

   // Queues bytes lo..hi-1 of a frame; the last byte is the checksum.
   task automatic push_frame(input byte_type cmd, input byte_type b2, input byte_type b3,
                             input byte_type b4, input byte_type b5, input byte_type b6,
                             input byte_type b7, input bit bad_sum = 1'b0,
                             input int lo = 0, input int hi = 9);
      byte_type f [9];
      f = '{SYNC_BYTE, cmd, b2, b3, b4, b5, b6, b7, 8'h00};
      for (int i = 1; i < 8; i++) f[8] = f[8] - f[i];
      if (bad_sum) f[8] = f[8] ^ byte_type'($urandom_range(1, 255));
      for (int i = lo; i < hi; i++) push_byte(f[i]);
   endtask

   task automatic push_random_frame(input bit active);
      byte_type cmd;
      byte_type unit;
      byte_type dec;
      half_type conc;
      int       pick;
      pick = $urandom_range(0, 9);
      if (pick < 8) cmd = active ? ($urandom_range(0, 1) ? GAS_A : GAS_B) : QUERY_CMD;
      else if (pick == 8) cmd = active ? QUERY_CMD : GAS_A;
      else cmd = byte_type'($urandom_range(0, 255));
      pick = $urandom_range(0, 4);
      unit = (pick < 2) ? UNIT_PPB : (pick < 4) ? UNIT_UGM3 : byte_type'($urandom_range(0, 255));
      dec  = ($urandom_range(0, 9) == 0) ? byte_type'($urandom_range(0, 255))
                                         : byte_type'($urandom_range(0, 6));
      pick = $urandom_range(0, 7);
      conc = (pick == 0) ? 16'hFFFF
           : (pick == 1) ? 16'h0000 : half_type'($urandom_range(0, 65535));
      push_frame(cmd, unit, dec, conc[15:8], conc[7:0], byte_type'($urandom_range(0, 255)),
                 byte_type'($urandom_range(0, 255)), $urandom_range(0, 9) == 0, 0,
                 ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : 9);
   endtask

   task automatic push_noise;
      int n;
      n = $urandom_range(1, 9);
      repeat (n)
         push_byte(($urandom_range(0, 3) == 0) ? SYNC_BYTE : byte_type'($urandom_range(0, 255)));
   endtask

   // Waits until every queued byte is taken and every result has come back,
   // then lets any bytes still in the pipeline pass through.
   task automatic wait_drained;
      while (pending_bytes.size() != 0 || req_valid || expected_readings.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_mode(input logic m);
      @(negedge clock);
      csr_valid       <= 1'b1;
      csr_active_mode <= m;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic phase_mode [5];
      phase_mode = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Active mode: saturated ppb conversion, both gas codes, the largest
      // decimals, an unknown unit, and a frame with a broken checksum.
      write_mode(1'b1);
      push_frame(GAS_A, UNIT_PPB, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      push_frame(GAS_B, UNIT_UGM3, 8'h05, 8'hFF, 8'hFF, 8'h00, 8'h00);
      push_frame(GAS_A, UNIT_PPB, 8'hFF, 8'h80, 8'h01, 8'h12, 8'h34);
      push_frame(GAS_B, 8'h00, 8'h02, 8'h00, 8'h00, 8'hA5, 8'h5A);
      push_frame(GAS_A, UNIT_UGM3, 8'h01, 8'h12, 8'h34, 8'h00, 8'h64, 1'b1);
      wait_drained();

      // A query frame started in active mode completes after the switch,
      // since a mode write leaves the window alone.
      push_frame(QUERY_CMD, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, 1'b0, 0, 5);
      wait_drained();
      write_mode(1'b0);
      push_frame(QUERY_CMD, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, 1'b0, 5, 9);
      push_frame(QUERY_CMD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      push_frame(GAS_A, UNIT_PPB, 8'h00, 8'h00, 8'h10, 8'h00, 8'h00);
      wait_drained();

      for (int ph = 0; ph < 5; ph++) begin
         write_mode(phase_mode[ph]);
         send_idle_on = (ph % 2 == 0);
         recv_idle_on = (ph != 3);
         bytes_pushed = 0;
         if (ph == 2) begin
            // Receiver holds off while frames arrive back to back.
            send_idle_on = 1'b0;
            hold_request = LongHoldOff;
            repeat (12)
               push_frame(GAS_B, UNIT_PPB, byte_type'($urandom_range(0, 6)),
                          byte_type'($urandom_range(0, 255)),
                          byte_type'($urandom_range(0, 255)),
                          byte_type'($urandom_range(0, 255)),
                          byte_type'($urandom_range(0, 255)));
         end
         while (bytes_pushed < PhaseBytes) begin
            if ($urandom_range(0, 9) < 7) push_random_frame(phase_mode[ph]);
            else push_noise();
         end
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (mismatches == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

@@ gas_sensor_frame_deframer.f @@
sv/gsfd_pkg.sv
sv/gsfd_convert.sv
sv/gas_sensor_frame_deframer.sv
tb/tb_gas_sensor_frame_deframer.sv
